### rtl/core/weighted_random_class_picker_top_defines.svh
// ----------------------------------------------------------------------------
// Weighted random class picker: assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_CLASS_PICKER_TOP_DEFINES_SVH
`define WEIGHTED_RANDOM_CLASS_PICKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define WRCP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define WRCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define WRCP_ASSERT_SAME(label, clk, rst, ante, cons)
`define WRCP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/wrcp_pkg.sv
// ----------------------------------------------------------------------------
// Weighted random class picker package
// Field widths, operation codes and reset constants of the picker.
// ----------------------------------------------------------------------------
`default_nettype none

package wrcp_pkg;

   localparam int OP_BITS     = 2;
   localparam int INDEX_BITS  = 5;
   localparam int VALUE_BITS  = 16;
   localparam int PERIOD_BITS = 16;

   localparam logic [OP_BITS-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_BITS-1:0] OP_TICK  = 2'd2;

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd500;
   localparam int                     ONE_WEIGHT   = 256;

   typedef logic [OP_BITS-1:0]     op_type;
   typedef logic [PERIOD_BITS-1:0] period_type;

endpackage

`default_nettype wire

### rtl/core/weighted_random_class_picker_top.sv
// ----------------------------------------------------------------------------
// Weighted random class picker
// Roulette wheel selection over a table of 8.8 weights, run every period.
// ----------------------------------------------------------------------------
// A weight write or an ignored operation is handled in the idle state; a clear
// writes zero to each entry in turn. A tick that ends a period runs one shared
// adder that totals, scales the draw and scans, and may then wait for the output.
// Synchronous reset clears control state; weights read as their reset values
// through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module weighted_random_class_picker_top
   import wrcp_pkg::*;
#(
   parameter int NUM_CLASSES = 18,
   parameter int WEIGHT_BITS = 16,
   parameter int RANDOM_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [OP_BITS-1:0]     req_operation,
   input  wire logic [INDEX_BITS-1:0]  req_class_index,
   input  wire logic [VALUE_BITS-1:0]  req_weight_value,
   input  wire logic [VALUE_BITS-1:0]  req_random_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [INDEX_BITS-1:0]       rsp_new_class,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [PERIOD_BITS-1:0] csr_wdata
);

`include "weighted_random_class_picker_top_defines.svh"

   localparam int IDX_BITS   = $clog2(NUM_CLASSES);
   localparam int TOTAL_BITS = WEIGHT_BITS + IDX_BITS;
   localparam int ACC_BITS   = TOTAL_BITS + 1;
   localparam int BIT_BITS   = $clog2(RANDOM_BITS);

   localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT = WEIGHT_BITS'(ONE_WEIGHT);
   localparam logic [IDX_BITS-1:0]    LAST_IDX     = IDX_BITS'(NUM_CLASSES - 1);
   localparam logic [BIT_BITS-1:0]    LAST_BIT     = BIT_BITS'(RANDOM_BITS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_SUM    = 3'd2;
   localparam logic [2:0] ST_SCALE  = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;

   logic [WEIGHT_BITS-1:0] weight_mem [NUM_CLASSES];

   logic [2:0]             state_ff, state_in;
   logic [IDX_BITS-1:0]    cnt_ff, cnt_in;
   logic [BIT_BITS-1:0]    bit_ff, bit_in;
   logic [PERIOD_BITS-1:0] tick_ff, tick_in;
   period_type             period_ff;
   logic [NUM_CLASSES-1:0] valid_ff, valid_in;
   logic                   vld_rd_ff;
   logic [WEIGHT_BITS-1:0] rd_data_ff;
   logic [TOTAL_BITS-1:0]  sum_ff, sum_in;
   logic [TOTAL_BITS-1:0]  acc_ff, acc_in;
   logic [RANDOM_BITS-1:0] rand_ff, rand_in;
   logic [IDX_BITS-1:0]    pick_ff, pick_in;
   logic [IDX_BITS-1:0]    cur_ff, cur_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]  rsp_class_ff, rsp_class_in;

   logic                   mem_we;
   logic [IDX_BITS-1:0]    mem_waddr;
   logic [WEIGHT_BITS-1:0] mem_wdata;
   logic [IDX_BITS-1:0]    rd_addr;
   logic [WEIGHT_BITS-1:0] w_eff;
   logic [ACC_BITS-1:0]    add_a, add_b, add_sum;
   logic [PERIOD_BITS-1:0] tick_next;
   logic [31:0]            weight_ext, random_ext;
   logic                   req_take, out_free;
   op_type                 req_op;

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_take      = req_valid && req_ready;
   assign req_op        = req_operation;
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_class = rsp_class_ff;
   assign out_free      = !rsp_valid_ff || rsp_ready;

   assign weight_ext = 32'(req_weight_value);
   assign random_ext = 32'(req_random_value);
   assign tick_next  = tick_ff + 16'd1;
   assign rd_addr    = cnt_in;

   assign w_eff = vld_rd_ff ? rd_data_ff
                : ((cnt_ff == '0) ? RESET_WEIGHT : '0);

   assign add_sum = add_a + add_b;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = '0;
      bit_in       = bit_ff;
      tick_in      = tick_ff;
      valid_in     = valid_ff;
      sum_in       = sum_ff;
      acc_in       = acc_ff;
      rand_in      = rand_ff;
      pick_in      = pick_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_class_in = rsp_class_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = '0;
      add_a        = ACC_BITS'(sum_ff);
      add_b        = ACC_BITS'(w_eff);
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_op)
                  OP_WRITE: begin
                     if (32'(req_class_index) < NUM_CLASSES) begin
                        mem_we    = 1'b1;
                        mem_waddr = IDX_BITS'(req_class_index);
                        mem_wdata = weight_ext[WEIGHT_BITS-1:0];
                     end
                  end
                  OP_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  OP_TICK: begin
                     if (tick_next >= period_ff) begin
                        tick_in  = '0;
                        rand_in  = random_ext[RANDOM_BITS-1:0];
                        sum_in   = '0;
                        state_in = ST_SUM;
                     end else begin
                        tick_in = tick_next;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = '0;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SUM: begin
            sum_in = add_sum[TOTAL_BITS-1:0];
            if (cnt_ff == LAST_IDX) begin
               acc_in = '0;
               bit_in = '0;
               if (sum_in == '0) begin
                  pick_in  = '0;
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCALE;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCALE: begin
            add_a  = ACC_BITS'(acc_ff);
            add_b  = rand_ff[bit_ff] ? ACC_BITS'(sum_ff) : '0;
            acc_in = add_sum[ACC_BITS-1:1];
            bit_in = bit_ff + 1'b1;
            if (bit_ff == LAST_BIT) begin
               sum_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            sum_in = add_sum[TOTAL_BITS-1:0];
            if ((w_eff != '0) && (acc_ff <= sum_in)) begin
               pick_in  = cnt_ff;
               state_in = ST_DECIDE;
            end else if (cnt_ff == LAST_IDX) begin
               pick_in  = '0;
               state_in = ST_DECIDE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            if (pick_ff == cur_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cur_in       = pick_ff;
               rsp_valid_in = 1'b1;
               rsp_class_in = INDEX_BITS'(pick_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (mem_we) begin
         valid_in[mem_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= weight_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         bit_ff       <= '0;
         tick_ff      <= '0;
         period_ff    <= PERIOD_RESET;
         valid_ff     <= '0;
         vld_rd_ff    <= 1'b0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bit_ff       <= bit_in;
         tick_ff      <= tick_in;
         valid_ff     <= valid_in;
         vld_rd_ff    <= valid_ff[rd_addr];
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            period_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      acc_ff       <= acc_in;
      rand_ff      <= rand_in;
      pick_ff      <= pick_in;
      rsp_class_ff <= rsp_class_in;
   end

   `WRCP_ASSERT_SAME(a_idle_cnt_zero, clock, reset, state_ff == ST_IDLE, cnt_ff == '0)
   `WRCP_ASSERT_SAME(a_emit_is_current, clock, reset, $rose(rsp_valid_ff), rsp_class_ff == INDEX_BITS'(cur_ff))
   `WRCP_ASSERT_NEXT(a_decide_waits, clock, reset, (state_ff == ST_DECIDE) && (pick_ff != cur_ff) && rsp_valid_ff && !rsp_ready, state_ff == ST_DECIDE)

endmodule

`default_nettype wire
